>>> rtl/gdz_pkg.sv
// ----------------------------------------------------------------------------
// gdz_pkg
// Shared types and constants for the gamepad dead zone normalizer.
// ----------------------------------------------------------------------------
package gdz_pkg;

  // pipeline depths of the iterative units, one bit per stage
  localparam int IsqSteps  = 16;
  localparam int DivSteps  = 16;
  // st1, st2, root, st19, st20, quotient, output register
  localparam int PipeDepth = IsqSteps + DivSteps + 5;

  localparam logic [15:0] StickOne = 16'd32768;
  localparam logic [15:0] AxisMax  = 16'd32767;
  localparam logic [15:0] TrigFull = 16'hFFFF;
  localparam logic [7:0]  TrigTop  = 8'd255;

  // register indexes on the config port
  typedef enum logic [1:0] {
    REG_TRIG_TH = 2'd0,
    REG_DZ_L    = 2'd1,
    REG_DZ_R    = 2'd2,
    REG_NONE    = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [7:0]  trig_th;
    logic [14:0] dz_l;
    logic [14:0] dz_r;
  } cfg_t;

  // sideband that rides along with the root pipeline
  typedef struct packed {
    logic [15:0]       buttons;
    logic [1:0][23:0]  trig_num;
    logic [7:0]        trig_den;
    logic [1:0]        trig_zero;
    logic [3:0][15:0]  ax_mag;
    logic [3:0]        ax_neg;
  } front_t;

  // sideband that rides along with the quotient pipeline
  typedef struct packed {
    logic [15:0] buttons;
    logic [3:0]  ax_neg;
    logic [1:0]  trig_zero;
    logic [1:0]  stick_zero;
  } back_t;

endpackage

>>> rtl/gdz_cfg.sv
// ----------------------------------------------------------------------------
// gdz_cfg
// APB register file: trigger threshold and the two stick dead zones.
// ----------------------------------------------------------------------------
module gdz_cfg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel_i,
  input  logic          penable_i,
  input  logic          pwrite_i,
  input  logic [3:0]    paddr_i,
  input  logic [31:0]   pwdata_i,
  output logic [31:0]   prdata_o,
  output gdz_pkg::cfg_t cfg_o
);
  import gdz_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr;

  assign idx = reg_idx_e'(paddr_i[3:2]);
  assign wr  = psel_i && penable_i && pwrite_i;

  // write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      unique case (idx)
        REG_TRIG_TH: cfg_d.trig_th = pwdata_i[7:0];
        REG_DZ_L:    cfg_d.dz_l    = pwdata_i[14:0];
        REG_DZ_R:    cfg_d.dz_r    = pwdata_i[14:0];
        default:     cfg_d         = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trig_th <= 8'd30;
      cfg_q.dz_l    <= 15'd7849;
      cfg_q.dz_r    <= 15'd8689;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      REG_TRIG_TH: prdata_o = {24'd0, cfg_q.trig_th};
      REG_DZ_L:    prdata_o = {17'd0, cfg_q.dz_l};
      REG_DZ_R:    prdata_o = {17'd0, cfg_q.dz_r};
      default:     prdata_o = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/gdz_isqrt.sv
// ----------------------------------------------------------------------------
// gdz_isqrt
// Pipelined floor integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module gdz_isqrt (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] val_i,
  output logic [15:0] root_o
);
  import gdz_pkg::*;

  logic [32:0] v_q [IsqSteps-1];
  logic [32:0] r_q [IsqSteps];

  for (genvar k = 0; k < IsqSteps; k++) begin : g_step
    localparam int Sh = 2 * (IsqSteps - 1 - k);
    logic [32:0] v_in, r_in, v_d, r_d, trial;

    if (k == 0) begin : g_first
      assign v_in = {1'b0, val_i};
      assign r_in = '0;
    end else begin : g_next
      assign v_in = v_q[k-1];
      assign r_in = r_q[k-1];
    end

    // trial subtract of the current bit pair
    always_comb begin
      trial = r_in + (33'd1 << Sh);
      if (v_in >= trial) begin
        v_d = v_in - trial;
        r_d = (r_in >> 1) + (33'd1 << Sh);
      end else begin
        v_d = v_in;
        r_d = r_in >> 1;
      end
    end

    if (k < IsqSteps - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) v_q[k] <= v_d;
      end
    end else begin : g_norem
      logic unused_v;
      assign unused_v = ^v_d;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) r_q[k] <= r_d;
    end
  end

  assign root_o = r_q[IsqSteps-1][15:0];

endmodule

>>> rtl/gdz_div.sv
// ----------------------------------------------------------------------------
// gdz_div
// Pipelined restoring divider, 46 by 31 bits, 16-bit quotient, one bit a stage.
// The caller guarantees the quotient fits in 16 bits.
// ----------------------------------------------------------------------------
module gdz_div (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [45:0] num_i,
  input  logic [30:0] den_i,
  output logic [15:0] quo_o
);
  import gdz_pkg::*;

  logic [45:0] rem_q [DivSteps-1];
  logic [30:0] den_q [DivSteps-1];
  logic [15:0] quo_q [DivSteps];

  for (genvar i = 0; i < DivSteps; i++) begin : g_step
    localparam int Sh = DivSteps - 1 - i;
    logic [45:0] rem_in, rem_d, shifted;
    logic [30:0] den_in;
    logic [15:0] quo_in, quo_d;

    if (i == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign den_in = den_q[i-1];
      assign quo_in = quo_q[i-1];
    end

    // compare and subtract the shifted divisor
    always_comb begin
      shifted = {15'd0, den_in} << Sh;
      if (rem_in >= shifted) begin
        rem_d = rem_in - shifted;
        quo_d = quo_in | (16'd1 << Sh);
      end else begin
        rem_d = rem_in;
        quo_d = quo_in;
      end
    end

    if (i < DivSteps - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[i] <= rem_d;
          den_q[i] <= den_in;
        end
      end
    end else begin : g_norem
      logic unused_r;
      assign unused_r = ^rem_d;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) quo_q[i] <= quo_d;
    end
  end

  assign quo_o = quo_q[DivSteps-1];

endmodule

>>> rtl/gamepad_dead_zone_normalizer.sv
// ----------------------------------------------------------------------------
// gamepad_dead_zone_normalizer
// Trigger threshold and scaled radial stick dead zone, fully pipelined.
//
//  channel  | direction | contents
//  s_axis   | in        | one raw sample per beat
//  m_axis   | out       | one normalized sample per beat
//  apb      | in/out    | trigger threshold, left and right dead zone
//
// One sample per cycle sustained unless m_axis stalls; the depth is set by the
// 16-stage root pipeline and the 16-stage quotient pipeline.
// A stall on m_axis freezes every stage at once; s_axis_tready follows it.
// Reset clears the valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
module gamepad_dead_zone_normalizer (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // buttons_in[15:0], left_trigger_raw[23:16], right_trigger_raw[31:24],
  // left_x_raw[47:32], left_y_raw[63:48], right_x_raw[79:64], right_y_raw[95:80]
  input  logic [95:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // buttons_out[15:0], left_trigger_level[31:16], right_trigger_level[47:32],
  // left_x_level[63:48], left_y_level[79:64], right_x_level[95:80],
  // right_y_level[111:96]
  output logic [111:0] m_axis_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import gdz_pkg::*;

  cfg_t cfg;
  logic en;
  logic [PipeDepth-1:0] vld_q, vld_d;

  gdz_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .cfg_o     (cfg)
  );
  assign pready = 1'b1;

  // global advance
  assign en            = !vld_q[PipeDepth-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[PipeDepth-1];

  // valid chain
  assign vld_d = {vld_q[PipeDepth-2:0], s_axis_tvalid};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  // st1: magnitudes, squares, trigger numerators
  front_t      s1_d, s1_q;
  logic [31:0] sq_d [4];
  logic [31:0] sq_q [4];
  always_comb begin
    logic [7:0]  traw [2];
    logic [15:0] ax;
    logic [7:0]  tdif;
    traw[0] = s_axis_tdata[23:16];
    traw[1] = s_axis_tdata[31:24];
    s1_d.buttons  = s_axis_tdata[15:0];
    s1_d.trig_den = TrigTop - cfg.trig_th;
    for (int t = 0; t < 2; t++) begin
      tdif = traw[t] - cfg.trig_th;
      s1_d.trig_zero[t] = (traw[t] < cfg.trig_th) || (cfg.trig_th == TrigTop);
      s1_d.trig_num[t]  = tdif * TrigFull;
    end
    for (int a = 0; a < 4; a++) begin
      ax = s_axis_tdata[32 + 16*a +: 16];
      s1_d.ax_neg[a] = ax[15];
      s1_d.ax_mag[a] = ax[15] ? (16'd0 - ax) : ax;
      sq_d[a]        = s1_d.ax_mag[a] * s1_d.ax_mag[a];
    end
  end

  // st2: sums of squares
  front_t      s2_q;
  logic [31:0] sum_q [2];

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q     <= s1_d;
      sq_q     <= sq_d;
      s2_q     <= s1_q;
      sum_q[0] <= sq_q[0] + sq_q[1];
      sum_q[1] <= sq_q[2] + sq_q[3];
    end
  end

  // magnitude roots
  logic [15:0] root [2];
  for (genvar s = 0; s < 2; s++) begin : g_root
    gdz_isqrt u_isqrt (
      .clk_i  (clk_i),
      .en_i   (en),
      .val_i  (sum_q[s]),
      .root_o (root[s])
    );
  end

  front_t sbd_q [IsqSteps];
  always_ff @(posedge clk_i) begin
    if (en) begin
      sbd_q[0] <= s2_q;
      for (int k = 1; k < IsqSteps; k++) sbd_q[k] <= sbd_q[k-1];
    end
  end

  // st19: dead zone test, scale numerator and denominator
  logic [30:0] num_d [2];
  logic [30:0] den_d [2];
  logic [1:0]  szero_d;
  always_comb begin
    logic [15:0] dz, mc, span;
    logic [31:0] prod;
    for (int s = 0; s < 2; s++) begin
      dz         = {1'b0, (s == 0) ? cfg.dz_l : cfg.dz_r};
      szero_d[s] = (root[s] < dz) || (root[s] == 16'd0);
      mc         = (root[s] > StickOne) ? StickOne : root[s];
      num_d[s]   = {mc - dz, 15'd0};
      span       = StickOne - dz;
      prod       = span * root[s];
      den_d[s]   = prod[30:0];
    end
  end

  front_t      s19_q;
  logic [30:0] num_q [2];
  logic [30:0] den_q [2];
  logic [1:0]  szero_q;

  // st20: divider operands
  logic [45:0] dnum_d [6];
  logic [30:0] dden_d [6];
  back_t       s20_d;
  always_comb begin
    logic [46:0] p;
    for (int a = 0; a < 4; a++) begin
      p         = s19_q.ax_mag[a] * num_q[a >> 1];
      dnum_d[a] = p[45:0];
      dden_d[a] = den_q[a >> 1];
    end
    for (int t = 0; t < 2; t++) begin
      dnum_d[4+t] = {22'd0, s19_q.trig_num[t]};
      dden_d[4+t] = {23'd0, s19_q.trig_den};
    end
    s20_d.buttons    = s19_q.buttons;
    s20_d.ax_neg     = s19_q.ax_neg;
    s20_d.trig_zero  = s19_q.trig_zero;
    s20_d.stick_zero = szero_q;
  end

  logic [45:0] dnum_q [6];
  logic [30:0] dden_q [6];
  back_t       s20_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s19_q   <= sbd_q[IsqSteps-1];
      num_q   <= num_d;
      den_q   <= den_d;
      szero_q <= szero_d;
      dnum_q  <= dnum_d;
      dden_q  <= dden_d;
      s20_q   <= s20_d;
    end
  end

  // quotients: four axes, then two triggers
  logic [15:0] quo [6];
  for (genvar d = 0; d < 6; d++) begin : g_div
    gdz_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (dnum_q[d]),
      .den_i (dden_q[d]),
      .quo_o (quo[d])
    );
  end

  back_t bd_q [DivSteps];
  always_ff @(posedge clk_i) begin
    if (en) begin
      bd_q[0] <= s20_q;
      for (int k = 1; k < DivSteps; k++) bd_q[k] <= bd_q[k-1];
    end
  end

  // output: saturate, sign, zero forcing
  back_t        bo;
  logic [111:0] out_d, out_q;
  always_comb begin
    logic [15:0] sat;
    bo = bd_q[DivSteps-1];
    out_d[15:0] = bo.buttons;
    for (int t = 0; t < 2; t++) begin
      out_d[16 + 16*t +: 16] = bo.trig_zero[t] ? 16'd0 : quo[4+t];
    end
    for (int a = 0; a < 4; a++) begin
      sat = (quo[a] > AxisMax) ? AxisMax : quo[a];
      if (bo.stick_zero[a >> 1]) begin
        out_d[48 + 16*a +: 16] = 16'd0;
      end else begin
        out_d[48 + 16*a +: 16] = bo.ax_neg[a] ? (16'd0 - sat) : sat;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) out_q <= out_d;
  end
  assign m_axis_tdata = out_q;

`ifndef SYNTH
  // a stall holds every valid bit in place
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("valid chain moved during stall");

  // a left trigger below threshold, or at a threshold of 255, leaves as zero
  a_trig_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && vld_q[PipeDepth-2] && bo.trig_zero[0] |=> m_axis_tdata[31:16] == 16'd0)
    else $error("left trigger not zero inside dead zone");

  // a left stick inside its dead zone gives both axes zero
  a_stick_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && vld_q[PipeDepth-2] && bo.stick_zero[0]
    |=> m_axis_tdata[63:48] == 16'd0 && m_axis_tdata[79:64] == 16'd0)
    else $error("left stick not zero inside dead zone");

  // saturation never lets the most negative code out
  a_no_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[63:48] != 16'h8000 &&
      m_axis_tdata[111:96] != 16'h8000)
    else $error("axis output not saturated");
`endif

endmodule

>>> verif/gamepad_dead_zone_normalizer_test.sv
// ----------------------------------------------------------------------------
// gamepad_dead_zone_normalizer_test
// Streams raw gamepad samples through the normalizer under random idling on
// both sides, predicts each normalized sample in the testbench and compares
// it field by field. Register settings are changed between phases, extremes
// included.
// ----------------------------------------------------------------------------
module gamepad_dead_zone_normalizer_test;
  import gdz_pkg::*;

  localparam int MaxCycles = 400000;
  localparam int DrainWait = PipeDepth + 8;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [95:0]  s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [111:0] m_axis_tdata;
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [3:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;

  gamepad_dead_zone_normalizer DUT (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // current register values as the predictor sees them
  logic [7:0]  trig_th;
  logic [14:0] dz_left;
  logic [14:0] dz_right;

  logic [111:0] sample_q[$];
  int  mismatch_cnt;
  int  cycle_cnt;
  bit  quiet_src;
  bit  quiet_snk;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // floor integer square root
  function automatic logic [15:0] root_of(logic [31:0] v);
    logic [32:0] rem;
    logic [32:0] res;
    logic [32:0] bitv;
    rem = {1'b0, v};
    res = '0;
    bitv = 33'h1_0000_0000;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res[15:0];
  endfunction

  function automatic logic [15:0] trig_level(logic [7:0] raw);
    if (raw < trig_th || trig_th == 8'd255) return '0;
    return 16'(((64'(raw) - trig_th) * 65535) / (255 - trig_th));
  endfunction

  function automatic logic [31:0] stick_levels(logic [15:0] xr, logic [15:0] yr,
                                                logic [14:0] dz);
    longint x, y, mag, mc, num, den, q;
    logic [15:0] res[2];
    x = longint'($signed(xr));
    y = longint'($signed(yr));
    mag = root_of(32'(x * x + y * y));
    if (mag < dz || mag == 0) return '0;
    mc = (mag > 32768) ? 32768 : mag;
    num = (mc - dz) * 32768;
    den = (32768 - dz) * mag;
    for (int k = 0; k < 2; k++) begin
      q = (((k == 0) ? x : y) < 0) ? -((k == 0) ? x : y) : ((k == 0) ? x : y);
      q = (q * num) / den;
      if (q > 32767) q = 32767;
      res[k] = (((k == 0) ? x : y) < 0) ? 16'(-q) : 16'(q);
    end
    return {res[1], res[0]};
  endfunction

  function automatic logic [111:0] normalize(logic [95:0] raw);
    return {stick_levels(raw[79:64], raw[95:80], dz_right),
            stick_levels(raw[47:32], raw[63:48], dz_left),
            trig_level(raw[31:24]), trig_level(raw[23:16]), raw[15:0]};
  endfunction

  // send one sample, idling at random before it
  task automatic send_sample(logic [95:0] raw);
    while (!quiet_src && $urandom_range(99) < 24) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tdata  <= raw;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sample_q.push_back(normalize(raw));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sample_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [31:0] val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= 4'(idx) << 2;
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_TRIG_TH: trig_th  = val[7:0];
      REG_DZ_L:    dz_left  = val[14:0];
      REG_DZ_R:    dz_right = val[14:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_regs(logic [7:0] th, logic [14:0] dl, logic [14:0] dr);
    drain();
    write_reg(REG_TRIG_TH, 32'(th));
    write_reg(REG_DZ_L, 32'(dl));
    write_reg(REG_DZ_R, 32'(dr));
  endtask

  function automatic logic [15:0] rand_axis();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($urandom_range(2000)) - 16'd1000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] rand_trig();
    case ($urandom_range(3))
      0: return trig_th;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  // corners at the reset register values
  task automatic test_directed();
    logic [15:0] ax[5];
    ax = '{16'h0000, 16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF};
    send_sample({16'h0, 16'h0, 16'h0, 16'h0, 8'd0, 8'd0, 16'h0000});
    send_sample({16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 8'd255, 8'd255, 16'hFFFF});
    send_sample({16'h8000, 16'h0000, 16'h0000, 16'h8000, 8'd30, 8'd29, 16'h5A5A});
    for (int k = 0; k < 5; k++)
      send_sample({ax[(k + 1) % 5], ax[k], ax[k], ax[(k + 2) % 5],
                   8'(k * 60), 8'(255 - k * 50), 16'(16'hA5A5 << k)});
    // magnitudes right around the dead zones
    send_sample({16'h0, 16'd8689, 16'h0, 16'd7849, 8'd31, 8'd31, 16'h0001});
    send_sample({16'h0, 16'd8688, 16'h0, 16'd7848, 8'd1, 8'd254, 16'h8000});
  endtask

  // thresholds of 255 and 0, dead zones of 0 and 32767, the extremes of the registers
  task automatic test_reg_extremes();
    set_regs(8'd255, 15'd0, 15'd32767);
    send_sample({16'h0, 16'h0, 16'h0, 16'h0, 8'd255, 8'd254, 16'h1234});
    send_sample({16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 8'd0, 8'd255, 16'h4321});
    send_sample({16'h0001, 16'h0, 16'h0, 16'hFFFF, 8'd128, 8'd255, 16'hFFFF});
    set_regs(8'd0, 15'd32767, 15'd0);
    send_sample({16'h0, 16'h0, 16'h0, 16'h0, 8'd0, 8'd255, 16'h0});
    send_sample({16'h8000, 16'h8000, 16'h8000, 16'h8000, 8'd1, 8'd254, 16'hFFFF});
    send_sample({16'h7FFF, 16'h0, 16'h5A82, 16'h5A82, 8'd100, 8'd7, 16'h0F0F});
  endtask

  task automatic test_random(int count);
    logic [95:0] raw;
    for (int i = 0; i < count; i++) begin
      quiet_src = (i % 300) >= 240;
      quiet_snk = quiet_src;
      raw = {rand_axis(), rand_axis(), rand_axis(), rand_axis(),
             rand_trig(), rand_trig(), 16'($urandom)};
      send_sample(raw);
    end
    quiet_src = 1'b0;
    quiet_snk = 1'b0;
  endtask

  task automatic test_random_settings();
    set_regs(8'd30, 15'd7849, 15'd8689);
    test_random(450);
    set_regs(8'($urandom_range(254)), 15'($urandom), 15'($urandom_range(4000)));
    test_random(450);
    set_regs(8'd254, 15'd1, 15'd16384);
    test_random(450);
  endtask

  // sink side: random stall and result check
  always @(posedge clk_i) begin
    m_axis_tready <= quiet_snk || ($urandom_range(99) >= 24);
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (sample_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected beat %h", m_axis_tdata);
      end else begin
        logic [111:0] want;
        want = sample_q.pop_front();
        for (int f = 0; f < 7; f++)
          if (want[f*16 +: 16] !== m_axis_tdata[f*16 +: 16]) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("field %0d: expected %h, got %h", f,
                       want[f*16 +: 16], m_axis_tdata[f*16 +: 16]);
          end
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > MaxCycles) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    trig_th       = 8'd30;
    dz_left       = 15'd7849;
    dz_right      = 15'd8689;
    mismatch_cnt  = 0;
    cycle_cnt     = 0;
    quiet_src     = 1'b0;
    quiet_snk     = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_reg_extremes();
    test_random_settings();
    drain();
    if (mismatch_cnt == 0 && sample_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
